// ===== hdl/nir_pkg.sv =====
// shared types and constants of the nec ir edge decoder
// no dependencies; imported by the front, back, top level and checker
package nir_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int EDGE_W   = 16;
  localparam int CODE_W   = 16;
  localparam int BITS_W   = 6;
  localparam int STATUS_W = 3;
  localparam int PHASE_W  = 7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam int UNIT_W  = 12;
  localparam int MARK_W  = 15;
  localparam int SPACE_W = 14;
  localparam int TOL_W   = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MARK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER_SPACE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SPACE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 3'd4;

  localparam logic [UNIT_W-1:0]  UNIT_RST         = 12'd562;
  localparam logic [MARK_W-1:0]  LEADER_MARK_RST  = 15'd8718;
  localparam logic [SPACE_W-1:0] LEADER_SPACE_RST = 14'd4500;
  localparam logic [SPACE_W-1:0] REPEAT_SPACE_RST = 14'd2250;
  localparam logic [TOL_W-1:0]   TOLERANCE_RST    = 12'd100;

  // phase encoding: idle, leader wait, then even phases per received bit
  localparam logic [PHASE_W-1:0] PH_IDLE      = 7'd1;
  localparam logic [PHASE_W-1:0] PH_LEADER    = 7'd2;
  localparam logic [PHASE_W-1:0] PH_FIRST_BIT = 7'd4;
  localparam logic [PHASE_W-1:0] PH_ADDR_END  = 7'd18;
  localparam logic [PHASE_W-1:0] PH_ADDRN_END = 7'd34;
  localparam logic [PHASE_W-1:0] PH_CMD_END   = 7'd50;
  localparam logic [3:0]         PH_BYTE_END  = 4'd2;

  localparam logic [BITS_W-1:0] BITS_FRAME = 6'd32;

  typedef enum logic [STATUS_W-1:0] {
    ST_PROGRESS = 3'd0,
    ST_OK       = 3'd1,
    ST_REPEAT   = 3'd2,
    ST_LONG     = 3'd3,
    ST_SHORT    = 3'd4,
    ST_INVERSE  = 3'd5
  } status_t;

  // timing class of one edge interval, computed by the front
  typedef struct packed {
    logic lead_long;
    logic lead_short;
    logic lead_rep;
    logic bit_long;
    logic bit_short;
    logic bit_one;
  } class_t;

  typedef struct packed {
    status_t             status;
    logic [CODE_W-1:0]   code;
    logic [BITS_W-1:0]   bits_received;
  } result_t;

endpackage

// ===== hdl/nir_fifo.sv =====
// small generic flip-flop queue with registered storage
// no dependencies; used between front and back and on the result side
module nir_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hdl/nir_front.sv =====
// front end: configuration registers, edge interval and timing classification
// depends on nir_pkg
module nir_front #(
  parameter int TIMER_WIDTH = nir_pkg::TIMER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [nir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nir_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            accept,
  input  logic [nir_pkg::EDGE_W-1:0]      edge_time,
  output nir_pkg::class_t                 cls
);

  import nir_pkg::*;

  localparam int EW = TIMER_WIDTH + EDGE_W;
  // signed compare width: thresholds stay within +-2^19
  localparam int CW = ((TIMER_WIDTH > 19) ? TIMER_WIDTH : 19) + 1;

  logic [UNIT_W-1:0]  unit_r;
  logic [MARK_W-1:0]  mark_r;
  logic [SPACE_W-1:0] space_r;
  logic [SPACE_W-1:0] rep_r;
  logic [TOL_W-1:0]   tol_r;
  logic [EDGE_W-1:0]  last_edge_r;

  logic [EW-1:0]          diff;
  logic [TIMER_WIDTH-1:0] delta;
  logic [CW-1:0]          d, u, m, s, r, t;
  logic [CW-1:0]          thr_lead_long, thr_lead_short, thr_lead_rep;
  logic [CW-1:0]          thr_bit_long, thr_bit_short, thr_bit_one;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r  <= UNIT_RST;
      mark_r  <= LEADER_MARK_RST;
      space_r <= LEADER_SPACE_RST;
      rep_r   <= REPEAT_SPACE_RST;
      tol_r   <= TOLERANCE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_UNIT:         unit_r  <= cfg_wdata[UNIT_W-1:0];
        CFG_LEADER_MARK:  mark_r  <= cfg_wdata[MARK_W-1:0];
        CFG_LEADER_SPACE: space_r <= cfg_wdata[SPACE_W-1:0];
        CFG_REPEAT_SPACE: rep_r   <= cfg_wdata[SPACE_W-1:0];
        CFG_TOLERANCE:    tol_r   <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
    end else if (accept) begin
      last_edge_r <= edge_time;
    end
  end

  // interval modulo the timer width
  assign diff  = EW'(edge_time) - EW'(last_edge_r);
  assign delta = diff[TIMER_WIDTH-1:0];

  assign d = CW'(delta);
  assign u = CW'(unit_r);
  assign m = CW'(mark_r);
  assign s = CW'(space_r);
  assign r = CW'(rep_r);
  assign t = CW'(tol_r);

  assign thr_lead_long  = m + s + (t << 3);
  assign thr_lead_short = m + r - t;
  assign thr_lead_rep   = m + s - t;
  assign thr_bit_long   = (u << 2) + t;
  assign thr_bit_short  = (u << 1) - t;
  assign thr_bit_one    = (u << 2) - t;

  always_comb begin
    cls.lead_long  = $signed(d) >  $signed(thr_lead_long);
    cls.lead_short = $signed(d) <  $signed(thr_lead_short);
    cls.lead_rep   = $signed(d) <  $signed(thr_lead_rep);
    cls.bit_long   = $signed(d) >  $signed(thr_bit_long);
    cls.bit_short  = $signed(d) <  $signed(thr_bit_short);
    cls.bit_one    = $signed(d) >= $signed(thr_bit_one);
  end

endmodule

// ===== hdl/nir_back.sv =====
// back end: leader and bit sequencing, byte checks and result forming
// depends on nir_pkg
module nir_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cls_valid,
  input  nir_pkg::class_t  cls,
  output logic             cls_pop,
  input  logic             res_full,
  output logic             res_push,
  output nir_pkg::result_t res
);

  import nir_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [7:0]         sb;
  logic [PHASE_W-1:0] bit_idx;
  status_t            st;
  logic               done;
  logic               fire;

  assign fire     = cls_valid && !res_full;
  assign cls_pop  = fire;
  assign res_push = fire;

  assign sb = {cls.bit_one, shift_r[7:1]};

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    code_nxt  = code_r;
    st        = ST_PROGRESS;
    done      = 1'b0;
    if (phase_r > 7'd3) begin
      if (cls.bit_long) begin
        phase_nxt = PH_LEADER;
        st        = ST_LONG;
      end else if (cls.bit_short) begin
        phase_nxt = PH_LEADER;
        st        = ST_SHORT;
      end else begin
        shift_nxt = sb;
        phase_nxt = phase_r + 7'd2;
        if (phase_r[3:0] == PH_BYTE_END) begin
          if (phase_r == PH_ADDR_END) begin
            code_nxt = {sb, 8'h00};
          end else if (phase_r == PH_ADDRN_END) begin
            if (~code_r[15:8] != sb) begin
              phase_nxt = PH_LEADER;
              st        = ST_INVERSE;
            end
          end else if (phase_r == PH_CMD_END) begin
            code_nxt = code_r | {8'h00, sb};
          end else if (~code_r[7:0] != sb) begin
            phase_nxt = PH_LEADER;
            st        = ST_INVERSE;
          end else begin
            phase_nxt = PH_IDLE;
            st        = ST_OK;
            done      = 1'b1;
          end
        end
      end
    end else if (phase_r == PH_LEADER) begin
      if (cls.lead_long) begin
        st = ST_LONG;
      end else if (cls.lead_short) begin
        st = ST_SHORT;
      end else if (cls.lead_rep) begin
        st = ST_REPEAT;
      end else begin
        phase_nxt = PH_FIRST_BIT;
      end
    end else begin
      // idle or a stray low phase: this edge opens the leader
      phase_nxt = PH_LEADER;
    end
  end

  assign bit_idx = phase_nxt - PH_FIRST_BIT;

  always_comb begin
    res.status = st;
    res.code   = code_nxt;
    if (done) begin
      res.bits_received = BITS_FRAME;
    end else if (phase_nxt >= PH_FIRST_BIT) begin
      res.bits_received = bit_idx[PHASE_W-1:1];
    end else begin
      res.bits_received = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      shift_r <= '0;
      code_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

// ===== hdl/nec_ir_edge_decoder.sv =====
// top level of the nec ir edge decoder: front, class queue, back, result queue
// depends on nir_pkg, nir_fifo, nir_front and nir_back
//
// Feed one beat per falling edge of the demodulated IR line, carrying the
// captured timer value; every edge yields exactly one result beat with the
// status, the current code and the number of data bits gathered. The block
// takes one edge per clock cycle while in_full is low: the front computes
// the interval and its timing class in the cycle of acceptance, a queue of
// QUEUE_DEPTH entries carries the class to the back, and the back updates
// the frame state and writes the result queue as it pops the class, while
// the result queue is not full. in_full rises only when the result side has
// been stalled long enough to fill both queues. Configuration is taken at
// any cycle with cfg_wr_en high but must only be changed while no edge is
// in flight; indexes beyond the register list are ignored.
module nec_ir_edge_decoder #(
  parameter int TIMER_WIDTH = nir_pkg::TIMER_WIDTH_DEF,
  parameter int QUEUE_DEPTH = nir_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [nir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nir_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [nir_pkg::EDGE_W-1:0]      in_edge_time,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [nir_pkg::STATUS_W-1:0]    out_status,
  output logic [nir_pkg::CODE_W-1:0]      out_code,
  output logic [nir_pkg::BITS_W-1:0]      out_bits_received
);

  import nir_pkg::*;

  localparam int CLS_W = $bits(class_t);
  localparam int RES_W = $bits(result_t);

  logic    in_accept;
  class_t  front_cls, back_cls;
  logic    cls_empty, cls_pop;
  logic    res_full, res_push;
  result_t back_res, out_res;

  assign in_accept = in_push && !in_full;

  nir_front #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (in_accept),
    .edge_time (in_edge_time),
    .cls       (front_cls)
  );

  nir_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_accept),
    .din   (front_cls),
    .full  (in_full),
    .pop   (cls_pop),
    .dout  (back_cls),
    .empty (cls_empty)
  );

  nir_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (!cls_empty),
    .cls       (back_cls),
    .cls_pop   (cls_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  nir_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_res),
    .empty (out_empty)
  );

  assign out_status        = out_res.status;
  assign out_code          = out_res.code;
  assign out_bits_received = out_res.bits_received;

endmodule

// ===== hdl/nir_checker.sv =====
// port-level checks of the nec ir edge decoder and their bind to the top level
// depends on nir_pkg and nec_ir_edge_decoder
module nir_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_full,
  input logic                            out_empty,
  input logic                            out_pop,
  input logic [nir_pkg::STATUS_W-1:0]    out_status,
  input logic [nir_pkg::CODE_W-1:0]      out_code,
  input logic [nir_pkg::BITS_W-1:0]      out_bits_received
);

  import nir_pkg::*;

  // reset leaves the result queue empty and the class queue not full
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a finished frame always reports all data bits
  a_ok_bits: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_status == ST_OK |-> out_bits_received == BITS_FRAME)
    else $error("frame ok without full bit count");

  // any error or repeat drops back to leader wait with no bits
  a_err_bits: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_status == ST_REPEAT || out_status == ST_LONG ||
                   out_status == ST_SHORT || out_status == ST_INVERSE)
    |-> out_bits_received == '0)
    else $error("error result with nonzero bit count");

  // a frame in progress never shows a full word
  a_progress_bits: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_status == ST_PROGRESS |-> out_bits_received < BITS_FRAME)
    else $error("in-progress result with full bit count");

  // a waiting result beat holds until it is popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_status) &&
                                $stable(out_code) && $stable(out_bits_received))
    else $error("waiting result beat changed");

endmodule

bind nec_ir_edge_decoder nir_checker u_nir_checker (.*);
